[rtl/separable_box_blur_3tap_rgb_assert.svh]
// Assertion macros used by the blur top-level RTL.
`ifndef SEPARABLE_BOX_BLUR_3TAP_RGB_ASSERT_SVH
`define SEPARABLE_BOX_BLUR_3TAP_RGB_ASSERT_SVH
`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent
`define SBB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbb: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent
`define SBB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbb: next-cycle check failed");
`else
`define SBB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/sbb_pkg.sv]
package sbb_pkg;

    localparam int CHAN_W   = 8;
    localparam int NUM_CH   = 3;
    localparam int PIX_W    = CHAN_W * NUM_CH;
    localparam int SUM_W    = 10;
    localparam int PROD_W   = 20;

    // floor(s / 3) for s <= 765 as (s * 683) >> 11
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;

    localparam int OUT_ROW_W  = 12;
    localparam int OUT_COL_W  = 11;

    // Configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam int WIDTH_RESET  = 1024;
    localparam int HEIGHT_RESET = 1024;

    typedef logic [CHAN_W-1:0] t_chan;
    // Channel 0 is red in bits 7:0, then green, then blue
    typedef logic [NUM_CH-1:0][CHAN_W-1:0] t_pix;

    typedef struct packed {
        t_chan                 red;
        t_chan                 green;
        t_chan                 blue;
        logic [OUT_ROW_W-1:0]  row;
        logic [OUT_COL_W-1:0]  col;
        logic                  frame_end;
        logic                  last_of_run;
    } t_res;

    function automatic logic [SUM_W-1:0] sum3(input t_chan a, input t_chan b, input t_chan c);
        return SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    endfunction

    function automatic t_chan div3(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(DIV3_MUL);
        return p[DIV3_SHIFT +: CHAN_W];
    endfunction

endpackage

[rtl/sbb_pix_if.sv]
interface sbb_pix_if;
    import sbb_pkg::*;

    logic  valid;
    logic  ready;
    t_chan red_in;
    t_chan green_in;
    t_chan blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

[rtl/sbb_res_if.sv]
interface sbb_res_if;
    import sbb_pkg::*;

    logic                 valid;
    logic                 ready;
    t_chan                red_out;
    t_chan                green_out;
    t_chan                blue_out;
    logic [OUT_ROW_W-1:0] out_row;
    logic [OUT_COL_W-1:0] out_col;
    logic                 frame_end;
    logic                 last_of_run;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output out_row, output out_col, output frame_end,
                    output last_of_run, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input out_row, input out_col, input frame_end,
                    input last_of_run, output ready);
endinterface

[rtl/separable_box_blur_3tap_rgb.sv]
// Streaming 3x3 box blur (separable, edges replicated) on 8-bit RGB pixels.
// i_pix takes pixels in raster order; o_res gives blurred pixels with their
// row and column, frame_end on the last pixel of the frame and last_of_run on
// the last result that an input pixel releases. Both are valid/ready channels.
// Frame size is set through the write port (index 0 width, 1 height); a write
// restarts the frame at row 0, column 0.
// Output row r-1 is produced while row r streams in; on the last row the
// results for the last two rows interleave column by column.
// A result passes through the job buffer, the column stage and the output
// register before it is valid on o_res.
// Throughput: one pixel per cycle inside a row while the receiver keeps up.
// The last pixel of a row releases two column jobs; on the last row a job
// gives two results (one if the frame has one row) through the single output
// register. The two line stores are read and written once per column job.
// Reset clears the counters and the pipeline; the line stores are not cleared
// and need no clearing pass. When the receiver stalls, the output register
// holds, the column stage waits on it and i_pix.ready drops once the job
// buffer is full.
`include "separable_box_blur_3tap_rgb_assert.svh"
module separable_box_blur_3tap_rgb #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [sbb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sbb_pix_if.sink                        i_pix,
    sbb_res_if.source                      o_res
);
    import sbb_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RST_COL_LAST = ((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1;
    localparam int RST_ROW_LAST =
        ((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET) - 1;

    // One column whose horizontal sum is ready
    typedef struct packed {
        logic [CW-1:0] col;
        logic [RW-1:0] row;
        t_pix          hsum;
        logic          row_ge1;
        logic          row_ge2;
        logic          last_row;
        logic          last_col;
        logic          tail;
    } t_job;

    // Configuration
    logic [CW-1:0] r_col_last;
    logic [RW-1:0] r_row_last;
    logic [31:0]   cfg_w_val;
    logic [31:0]   cfg_h_val;
    logic [31:0]   cfg_w_last;
    logic [31:0]   cfg_h_last;

    // Input side
    logic          in_fire;
    logic          in_ready;
    t_pix          pix_in;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_pix          r_prev1;
    t_pix          r_prev2;
    logic          lastc;
    logic          lastr;
    logic          c_ge1;
    logic          c_ge2;
    t_pix          h_mid;
    t_pix          h_end;
    t_job          job_mid;
    t_job          job_end;

    // Job buffer
    logic r_f0_v, n_f0_v, r_f1_v, n_f1_v;
    t_job r_f0, n_f0, r_f1, n_f1;
    logic f_pop;

    // Column stage
    logic          r_j_v;
    t_job          r_j;
    logic          r_j_phase;
    logic          j_done;
    logic          has_a;
    logic          has_b;
    logic          emit_b;
    logic          emit_fire;
    logic [CW-1:0] rd_addr;
    t_pix          above_rd;
    t_pix          cur_rd;
    t_pix          above;
    t_pix          mid;
    logic          r_fwd;
    t_pix          r_fwd_above;
    t_pix          r_fwd_cur;
    t_pix          res_prev;
    t_pix          res_last;
    t_res          n_res;

    // Output register
    logic r_o_v;
    t_res r_o;
    logic out_free;

    // Clamp the written size to 1..MAX and keep the last index
    always_comb begin
        cfg_w_val = 32'(i_cfg_data[CFG_WIDTH_W-1:0]);
        cfg_h_val = 32'(i_cfg_data[CFG_HEIGHT_W-1:0]);
        if (cfg_w_val == 32'd0) begin
            cfg_w_last = 32'd0;
        end else if (cfg_w_val > 32'(MAX_WIDTH)) begin
            cfg_w_last = 32'(MAX_WIDTH - 1);
        end else begin
            cfg_w_last = cfg_w_val - 32'd1;
        end
        if (cfg_h_val == 32'd0) begin
            cfg_h_last = 32'd0;
        end else if (cfg_h_val > 32'(MAX_HEIGHT)) begin
            cfg_h_last = 32'(MAX_HEIGHT - 1);
        end else begin
            cfg_h_last = cfg_h_val - 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= CW'(RST_COL_LAST);
            r_row_last <= RW'(RST_ROW_LAST);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_col_last <= cfg_w_last[CW-1:0];
                CFG_IMAGE_HEIGHT: r_row_last <= cfg_h_last[RW-1:0];
                default: ;
            endcase
        end
    end

    // Input transfer and position
    assign in_fire        = i_pix.valid && in_ready;
    assign i_pix.ready    = in_ready;
    assign pix_in[0]      = i_pix.red_in;
    assign pix_in[1]      = i_pix.green_in;
    assign pix_in[2]      = i_pix.blue_in;
    assign lastc          = (r_col == r_col_last);
    assign lastr          = (r_row == r_row_last);
    assign c_ge1          = (r_col != '0);
    assign c_ge2          = ({1'b0, r_col} >= (CW + 1)'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_wr_en) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            if (lastc) begin
                r_col <= '0;
                r_row <= lastr ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Shift the pixel window
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_prev2 <= r_prev1;
            r_prev1 <= pix_in;
        end
    end

    // Per-channel lanes: horizontal pass at the input, vertical pass per column
    for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
        sbb_hlane u_hlane (
            .i_prev2    (r_prev2[g]),
            .i_prev1    (r_prev1[g]),
            .i_cur      (pix_in[g]),
            .i_col_ge1  (c_ge1),
            .i_col_ge2  (c_ge2),
            .o_hsum_mid (h_mid[g]),
            .o_hsum_end (h_end[g])
        );
        sbb_vlane u_vlane (
            .i_above    (above[g]),
            .i_mid      (mid[g]),
            .i_hsum     (r_j.hsum[g]),
            .i_row_ge1  (r_j.row_ge1),
            .i_row_ge2  (r_j.row_ge2),
            .o_res_prev (res_prev[g]),
            .o_res_last (res_last[g])
        );
    end

    // Build the column jobs released by this pixel
    always_comb begin
        job_mid.col      = r_col - CW'(1);
        job_mid.row      = r_row;
        job_mid.hsum     = h_mid;
        job_mid.row_ge1  = (r_row != '0);
        job_mid.row_ge2  = ({1'b0, r_row} >= (RW + 1)'(2));
        job_mid.last_row = lastr;
        job_mid.last_col = 1'b0;
        job_mid.tail     = !lastc;
        job_end          = job_mid;
        job_end.col      = r_col;
        job_end.hsum     = h_end;
        job_end.last_col = 1'b1;
        job_end.tail     = 1'b1;
    end

    // Job buffer: two slots, drained one job per cycle when not stalled
    assign f_pop    = r_f0_v && (!r_j_v || j_done);
    assign in_ready = !r_f0_v || (f_pop && !r_f1_v);

    always_comb begin
        n_f0_v = r_f0_v;
        n_f1_v = r_f1_v;
        n_f0   = r_f0;
        n_f1   = r_f1;
        if (f_pop) begin
            n_f0_v = r_f1_v;
            n_f0   = r_f1;
            n_f1_v = 1'b0;
        end
        if (in_fire) begin
            if (c_ge1) begin
                n_f0_v = 1'b1;
                n_f0   = job_mid;
                n_f1_v = lastc;
                n_f1   = job_end;
            end else if (lastc) begin
                n_f0_v = 1'b1;
                n_f0   = job_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
            r_f1_v <= 1'b0;
        end else begin
            r_f0_v <= n_f0_v;
            r_f1_v <= n_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f0 <= n_f0;
        r_f1 <= n_f1;
    end

    // Line stores: read as a job enters the column stage, write as it leaves
    assign rd_addr = f_pop ? r_f0.col : r_j.col;

    sbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_ram_above (
        .i_clk     (i_clk),
        .i_wr_en   (j_done),
        .i_wr_addr (r_j.col),
        .i_wr_data (mid),
        .i_rd_addr (rd_addr),
        .o_rd_data (above_rd)
    );

    sbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_ram_cur (
        .i_clk     (i_clk),
        .i_wr_en   (j_done),
        .i_wr_addr (r_j.col),
        .i_wr_data (r_j.hsum),
        .i_rd_addr (rd_addr),
        .o_rd_data (cur_rd)
    );

    // Bypass the store when a job follows one on the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (f_pop) begin
            r_fwd <= j_done && (r_f0.col == r_j.col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_pop) begin
            r_fwd_above <= mid;
            r_fwd_cur   <= r_j.hsum;
        end
    end

    assign above = r_fwd ? r_fwd_above : above_rd;
    assign mid   = r_fwd ? r_fwd_cur : cur_rd;

    // Column stage sequencing: up to two results per job
    assign has_a     = r_j.row_ge1;
    assign has_b     = r_j.last_row;
    assign emit_b    = r_j_phase || !has_a;
    assign out_free  = !r_o_v || o_res.ready;
    assign emit_fire = r_j_v && (has_a || has_b) && out_free;
    assign j_done    = r_j_v && (!(has_a || has_b) || (emit_fire && (emit_b || !has_b)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_v     <= 1'b0;
            r_j_phase <= 1'b0;
        end else begin
            if (f_pop) begin
                r_j_v <= 1'b1;
            end else if (j_done) begin
                r_j_v <= 1'b0;
            end
            if (j_done) begin
                r_j_phase <= 1'b0;
            end else if (emit_fire) begin
                r_j_phase <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_pop) begin
            r_j <= r_f0;
        end
    end

    // Merge the lane results into one output item
    always_comb begin
        if (emit_b) begin
            n_res.red   = res_last[0];
            n_res.green = res_last[1];
            n_res.blue  = res_last[2];
            n_res.row   = OUT_ROW_W'(r_j.row);
        end else begin
            n_res.red   = res_prev[0];
            n_res.green = res_prev[1];
            n_res.blue  = res_prev[2];
            n_res.row   = OUT_ROW_W'(r_j.row - RW'(1));
        end
        n_res.col         = OUT_COL_W'(r_j.col);
        n_res.frame_end   = emit_b && r_j.last_col;
        n_res.last_of_run = r_j.tail && (emit_b || !has_b);
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (emit_fire) begin
            r_o_v <= 1'b1;
        end else if (o_res.ready) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_o <= n_res;
        end
    end

    assign o_res.valid       = r_o_v;
    assign o_res.red_out     = r_o.red;
    assign o_res.green_out   = r_o.green;
    assign o_res.blue_out    = r_o.blue;
    assign o_res.out_row     = r_o.row;
    assign o_res.out_col     = r_o.col;
    assign o_res.frame_end   = r_o.frame_end;
    assign o_res.last_of_run = r_o.last_of_run;

    // Checks
    `SBB_ASSERT_IMP(a_slot_order, i_clk, i_rst_n, r_f1_v, r_f0_v)
    `SBB_ASSERT_IMP(a_no_take_when_full, i_clk, i_rst_n, in_fire, !r_f1_v)
    `SBB_ASSERT_IMP(a_frame_end_last, i_clk, i_rst_n, r_o_v && r_o.frame_end,
        r_o.last_of_run)
    `SBB_ASSERT_NXT(a_second_result, i_clk, i_rst_n,
        emit_fire && !r_j_phase && has_a && has_b, r_j_v && r_j_phase)
endmodule

[rtl/sbb_ram.sv]
module sbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

[rtl/sbb_hlane.sv]
module sbb_hlane (
    input  sbb_pkg::t_chan i_prev2,
    input  sbb_pkg::t_chan i_prev1,
    input  sbb_pkg::t_chan i_cur,
    input  logic           i_col_ge1,
    input  logic           i_col_ge2,
    output sbb_pkg::t_chan o_hsum_mid,
    output sbb_pkg::t_chan o_hsum_end
);
    import sbb_pkg::*;

    t_chan left_mid;
    t_chan left_end;

    // Replicate the edge pixel where the left neighbour is missing
    assign left_mid = i_col_ge2 ? i_prev2 : i_prev1;
    assign left_end = i_col_ge1 ? i_prev1 : i_cur;

    // Column one to the left, centred on the previous pixel
    assign o_hsum_mid = div3(sum3(left_mid, i_prev1, i_cur));
    // Last column of the row: right neighbour replicated
    assign o_hsum_end = div3(sum3(left_end, i_cur, i_cur));
endmodule

[rtl/sbb_vlane.sv]
module sbb_vlane (
    input  sbb_pkg::t_chan i_above,
    input  sbb_pkg::t_chan i_mid,
    input  sbb_pkg::t_chan i_hsum,
    input  logic           i_row_ge1,
    input  logic           i_row_ge2,
    output sbb_pkg::t_chan o_res_prev,
    output sbb_pkg::t_chan o_res_last
);
    import sbb_pkg::*;

    t_chan up_prev;
    t_chan up_last;

    // Replicate the top row where there is no row above
    assign up_prev = i_row_ge2 ? i_above : i_mid;
    assign up_last = i_row_ge1 ? i_mid : i_hsum;

    // Row above the incoming one, now complete
    assign o_res_prev = div3(sum3(up_prev, i_mid, i_hsum));
    // Final row of the frame: bottom row replicated
    assign o_res_last = div3(sum3(up_last, i_hsum, i_hsum));
endmodule
